// ===== sv/smvm_pkg.sv =====
// Shared types and constants for the sparse row matrix-vector multiply unit.
`default_nettype none
package smvm_pkg;

  localparam int VEC_DEPTH_DEF = 1024;
  localparam int MID_DEPTH     = 4;
  localparam int OUT_DEPTH     = 4;
  localparam int CNT_W         = $clog2(OUT_DEPTH + 1);
  localparam int ACC_W         = 48;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_ENTRY = 1'b1
  } req_e;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] operand;
    logic        add_ok;
    logic        stop;
    logic        last;
  } smvm_entry_t;

  typedef struct packed {
    logic [15:0] row_index;
    logic [31:0] row_sum;
    logic        overflow;
  } smvm_result_t;

endpackage
`default_nettype wire

// ===== sv/smvm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module smvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/smvm_fifo.sv =====
// Small register queue with occupancy count.
`default_nettype none
module smvm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire logic [WIDTH-1:0]             data_i,
  input  wire logic                         pop_i,
  output      logic [WIDTH-1:0]             data_o,
  output      logic                         empty_o,
  output      logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule
`default_nettype wire

// ===== sv/smvm_front.sv =====
// Front end: accepts words, writes vector loads, fetches operands for matrix entries.
`default_nettype none
module smvm_front
  import smvm_pkg::*;
#(
  parameter int VEC_DEPTH = VEC_DEPTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  output      logic                       full,
  input  wire logic                       req_type_i,
  input  wire logic [9:0]                 vec_index_i,
  input  wire logic signed [31:0]         value_i,
  input  wire logic [10:0]                column_i,
  input  wire logic                       last_in_row_i,
  input  wire logic [$clog2(MID_DEPTH+1)-1:0] mid_count_i,
  output      logic                       entry_push_o,
  output      smvm_entry_t                entry_o
);

  localparam int AW = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
  localparam int MCW = $clog2(MID_DEPTH + 1);

  logic          accept;
  logic          is_entry;
  logic          load_ok;
  logic          add_ok;
  logic [10:0]   col_m1;
  logic [16:0]   widx_ext;
  logic [16:0]   ridx_ext;
  logic          we;
  logic          re;
  logic [31:0]   rdata;
  logic [MCW:0]  used;

  logic          s1_valid_q;
  logic [31:0]   s1_value_q;
  logic          s1_add_ok_q;
  logic          s1_stop_q;
  logic          s1_last_q;

  assign used     = {1'b0, mid_count_i} + (MCW + 1)'(s1_valid_q);
  assign full     = (32'(used) >= MID_DEPTH);
  assign accept   = push && !full;
  assign is_entry = (req_e'(req_type_i) == REQ_ENTRY);

  assign load_ok  = (32'(vec_index_i) < VEC_DEPTH);
  assign col_m1   = column_i - 11'd1;
  assign add_ok   = (column_i != 11'd0) && (32'(col_m1) < VEC_DEPTH);
  assign widx_ext = 17'(vec_index_i);
  assign ridx_ext = 17'(col_m1);

  assign we = accept && !is_entry && load_ok;
  assign re = accept && is_entry;

  smvm_ram #(
    .WIDTH (32),
    .DEPTH (VEC_DEPTH)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (widx_ext[AW-1:0]),
    .wdata_i (value_i),
    .re_i    (re),
    .raddr_i (ridx_ext[AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      s1_value_q  <= value_i;
      s1_add_ok_q <= add_ok;
      s1_stop_q   <= (column_i == 11'd0);
      s1_last_q   <= last_in_row_i;
    end
  end

  assign entry_push_o    = s1_valid_q;
  assign entry_o.value   = s1_value_q;
  assign entry_o.operand = rdata;
  assign entry_o.add_ok  = s1_add_ok_q;
  assign entry_o.stop    = s1_stop_q;
  assign entry_o.last    = s1_last_q;

endmodule
`default_nettype wire

// ===== sv/smvm_back.sv =====
// Back end: multiply, accumulate per row, close rows into results.
`default_nettype none
module smvm_back
  import smvm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               entry_empty_i,
  input  wire smvm_entry_t        entry_i,
  output      logic               entry_pop_o,
  input  wire logic [CNT_W-1:0]   out_count_i,
  output      logic               res_push_o,
  output      smvm_result_t       res_o
);

  logic [CNT_W+1:0]        inflight;
  logic signed [63:0]      prod;

  logic                    b1_valid_q;
  logic [ACC_W-1:0]        b1_prod_q;
  logic                    b1_add_q;
  logic                    b1_stop_q;
  logic                    b1_last_q;

  logic [ACC_W-1:0]        acc_q, acc_d, acc_upd;
  logic                    stopped_q, stopped_d;
  logic [15:0]             row_q, row_d;
  logic                    res_valid_q, res_valid_d;
  logic [ACC_W-1:0]        res_acc_q;
  logic [15:0]             res_row_q;
  logic [ACC_W:0]          sum;
  logic [ACC_W-1:0]        sum_sat;
  logic                    close;

  assign inflight = (CNT_W + 2)'(out_count_i) + (CNT_W + 2)'(b1_valid_q && b1_last_q)
                  + (CNT_W + 2)'(res_valid_q);
  assign entry_pop_o = !entry_empty_i && (32'(inflight) < OUT_DEPTH);

  assign prod = $signed(entry_i.value) * $signed(entry_i.operand);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
    end else begin
      b1_valid_q <= entry_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_pop_o) begin
      b1_prod_q <= prod[63:16];
      b1_add_q  <= entry_i.add_ok;
      b1_stop_q <= entry_i.stop;
      b1_last_q <= entry_i.last;
    end
  end

  assign sum   = {acc_q[ACC_W-1], acc_q} + {b1_prod_q[ACC_W-1], b1_prod_q};
  assign close = b1_valid_q && b1_last_q;

  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sum_sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sum_sat = sum[ACC_W-1:0];
    end
    acc_upd = (b1_valid_q && b1_add_q && !b1_stop_q && !stopped_q) ? sum_sat : acc_q;

    acc_d       = acc_upd;
    stopped_d   = stopped_q || (b1_valid_q && b1_stop_q);
    row_d       = row_q;
    res_valid_d = 1'b0;
    if (close) begin
      acc_d       = '0;
      stopped_d   = 1'b0;
      row_d       = row_q + 16'd1;
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      stopped_q   <= 1'b0;
      row_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      stopped_q   <= stopped_d;
      row_q       <= row_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (close) begin
      res_acc_q <= acc_upd;
      res_row_q <= row_q;
    end
  end

  always_comb begin
    res_o.row_index = res_row_q;
    if (res_acc_q[ACC_W-1:31] != {(ACC_W-31){res_acc_q[ACC_W-1]}}) begin
      res_o.overflow = 1'b1;
      res_o.row_sum  = res_acc_q[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      res_o.overflow = 1'b0;
      res_o.row_sum  = res_acc_q[31:0];
    end
  end

  assign res_push_o = res_valid_q;

endmodule
`default_nettype wire

// ===== sv/sparse_row_matrix_vector_multiply_unit.sv =====
// Top level: row-compressed sparse matrix times dense vector.
// A closed row passes product register, result register and output queue before empty falls.
// Throughput: one word per cycle, loads and matrix entries alike, while full is low.
// The vector store is one memory port pair: a load writes, an entry reads, once per cycle.
// Reset clears row accumulator, stop flag, row counter and queues; vector store is not cleared.
`default_nettype none
module sparse_row_matrix_vector_multiply_unit
  import smvm_pkg::*;
#(
  parameter int VEC_DEPTH = VEC_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output      logic               full,
  input  wire logic               req_type_i,
  input  wire logic [9:0]         vec_index_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [10:0]        column_i,
  input  wire logic               last_in_row_i,
  output      logic               empty,
  input  wire logic               pop,
  output      logic [15:0]        row_index_o,
  output      logic signed [31:0] row_sum_o,
  output      logic               overflow_o
);

  localparam int EW = $bits(smvm_entry_t);
  localparam int RW = $bits(smvm_result_t);

  logic                               entry_push;
  smvm_entry_t                        entry_in;
  smvm_entry_t                        entry_out;
  logic [EW-1:0]                      entry_raw;
  logic                               entry_pop;
  logic                               entry_empty;
  logic [$clog2(MID_DEPTH+1)-1:0]     mid_count;
  logic                               res_push;
  smvm_result_t                       res_in;
  smvm_result_t                       res_out;
  logic [RW-1:0]                      res_raw;
  logic [CNT_W-1:0]                   out_count;

  smvm_front #(
    .VEC_DEPTH (VEC_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .req_type_i    (req_type_i),
    .vec_index_i   (vec_index_i),
    .value_i       (value_i),
    .column_i      (column_i),
    .last_in_row_i (last_in_row_i),
    .mid_count_i   (mid_count),
    .entry_push_o  (entry_push),
    .entry_o       (entry_in)
  );

  smvm_fifo #(
    .WIDTH (EW),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (entry_push),
    .data_i  (entry_in),
    .pop_i   (entry_pop),
    .data_o  (entry_raw),
    .empty_o (entry_empty),
    .count_o (mid_count)
  );

  assign entry_out = smvm_entry_t'(entry_raw);

  smvm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_empty_i (entry_empty),
    .entry_i       (entry_out),
    .entry_pop_o   (entry_pop),
    .out_count_i   (out_count),
    .res_push_o    (res_push),
    .res_o         (res_in)
  );

  smvm_fifo #(
    .WIDTH (RW),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop && !empty),
    .data_o  (res_raw),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign res_out     = smvm_result_t'(res_raw);
  assign row_index_o = res_out.row_index;
  assign row_sum_o   = res_out.row_sum;
  assign overflow_o  = res_out.overflow;

endmodule
`default_nettype wire
